@@ sv/ckpe_pkg.sv @@
// Package for the colour key point extractor.
// Holds the record and status codes, register indexes and the queue entry type.
// No dependencies.
package ckpe_pkg;

	localparam int NUM_REFS = 4;
	localparam int NUM_TRACES = 4;
	localparam int COORD_W = 10;
	localparam int COUNT_W = 4;
	localparam int DEF_COLOR_BITS = 8;
	localparam int DEF_MIN_TRACE_POINTS = 10;
	localparam int DEF_MAX_TRACES = 4;
	localparam int DEF_QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		REC_PIXEL  = 2'd0,
		REC_REF    = 2'd1,
		REC_STATUS = 2'd2
	} rec_kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FIRST_BAD = 3'd1,
		ST_REF_MISS  = 3'd2,
		ST_FEW_PTS   = 3'd3,
		ST_EXCESS    = 3'd4
	} status_t;

	localparam logic [2:0] REG_WIDTH        = 3'd0;
	localparam logic [2:0] REG_HEIGHT       = 3'd1;
	localparam logic [2:0] REG_TRACE_COUNT  = 3'd2;
	localparam logic [2:0] REG_REF_COLORS   = 3'd3;
	localparam logic [2:0] REG_TRACE_COLORS = 3'd4;

	localparam logic [2:0] SUB_PIXEL  = 3'd0;
	localparam logic [2:0] SUB_STATUS = 3'd5;

	typedef struct packed {
		logic                                is_last;
		logic [COORD_W-1:0]                  x;
		logic [COORD_W-1:0]                  y;
		logic                                hit;
		logic [1:0]                          idx;
		logic [NUM_TRACES-1:0]               mask;
		logic [NUM_REFS-1:0]                 rv;
		logic [NUM_REFS-1:0][COORD_W-1:0]    rx;
		logic [NUM_REFS-1:0][COORD_W-1:0]    ry;
		status_t                             st;
		logic [1:0]                          sidx;
		logic [NUM_TRACES-1:0]               smask;
	} ckpe_entry_t;

endpackage

@@ sv/ckpe_front.sv @@
// Front end: configuration registers, position counters and per-image state.
// Classifies each pixel beat and pushes one entry per pixel into the queue.
// Depends on ckpe_pkg.
module ckpe_front import ckpe_pkg::*; #(
	parameter int COLOR_BITS = DEF_COLOR_BITS,
	parameter int MIN_TRACE_POINTS = DEF_MIN_TRACE_POINTS,
	parameter int MAX_TRACES = DEF_MAX_TRACES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  logic [7:0]  pixel_color,
	input  logic        final_pixel,
	input  logic        q_full,
	output logic        q_push,
	output ckpe_entry_t q_entry
);

	localparam int CMP_BITS = (COLOR_BITS < 8) ? COLOR_BITS : 8;

	logic [COORD_W-1:0] width_q, height_q;
	logic [2:0]         trace_count_q;
	logic [31:0]        ref_colors_q, trace_colors_q;

	logic [COORD_W-1:0] col_q, row_q;
	logic               first_seen_q, first_bad_q, excess_q;
	logic [NUM_REFS-1:0] rv_q;
	logic [NUM_REFS-1:0][COORD_W-1:0] rx_q, ry_q;
	logic [NUM_TRACES-1:0][COUNT_W-1:0] tp_q;

	logic [2:0]         ntr;
	logic               in_image, hit, first_bad_n, excess_n, accept;
	logic [1:0]         idx, sidx;
	logic [NUM_TRACES-1:0] mask, smask, en;
	logic [COORD_W-1:0] y;
	logic [NUM_REFS-1:0] rv_n;
	logic [NUM_REFS-1:0][COORD_W-1:0] rx_n, ry_n;
	logic [NUM_TRACES-1:0][COUNT_W-1:0] tp_n;
	logic [2:0]         missing;
	status_t            st;
	logic [COORD_W-1:0] col_n, row_n;

	assign cfg_ready = 1'b1;
	assign pixel_ready = !q_full;
	assign accept = pixel_valid && !q_full;
	assign q_push = accept;

	always_comb begin
		ntr = (trace_count_q > 3'(MAX_TRACES)) ? 3'(MAX_TRACES) : trace_count_q;
		in_image = row_q < height_q;
		y = in_image ? (height_q - 10'd1 - row_q) : 10'd0;
		excess_n = excess_q || !in_image;
		first_bad_n = first_bad_q;
		if (!first_seen_q && (pixel_color[CMP_BITS-1:0] != '0)) begin
			first_bad_n = 1'b1;
		end
		hit = 1'b0;
		idx = 2'd0;
		for (int i = NUM_REFS - 1; i >= 0; i--) begin
			if (pixel_color[CMP_BITS-1:0] == ref_colors_q[8*i +: CMP_BITS]) begin
				hit = 1'b1;
				idx = 2'(i);
			end
		end
		rv_n = rv_q;
		rx_n = rx_q;
		ry_n = ry_q;
		if (in_image && hit) begin
			rv_n[idx] = 1'b1;
			rx_n[idx] = col_q;
			ry_n[idx] = y;
		end
		for (int i = 0; i < NUM_TRACES; i++) begin
			en[i] = 3'(i) < ntr;
			mask[i] = en[i] &&
				(pixel_color[CMP_BITS-1:0] == trace_colors_q[8*i +: CMP_BITS]);
			tp_n[i] = tp_q[i];
			if (in_image && mask[i] && (tp_q[i] != 4'd15)) begin
				tp_n[i] = tp_q[i] + 4'd1;
			end
			smask[i] = en[i] && (tp_n[i] < COUNT_W'(MIN_TRACE_POINTS));
		end
		missing = 3'(NUM_REFS);
		for (int i = NUM_REFS - 1; i >= 0; i--) begin
			if (!rv_n[i]) begin
				missing = 3'(i);
			end
		end
		sidx = 2'd0;
		st = ST_OK;
		if (first_bad_n) begin
			st = ST_FIRST_BAD;
		end else if (missing != 3'(NUM_REFS)) begin
			st = ST_REF_MISS;
			sidx = missing[1:0];
		end else if (smask != '0) begin
			st = ST_FEW_PTS;
		end else if (excess_n) begin
			st = ST_EXCESS;
		end
		if (({1'b0, col_q} + 11'd1) >= {1'b0, width_q}) begin
			col_n = '0;
			row_n = (row_q != 10'd1023) ? row_q + 10'd1 : row_q;
		end else begin
			col_n = col_q + 10'd1;
			row_n = row_q;
		end
		q_entry.is_last = final_pixel;
		q_entry.x = col_q;
		q_entry.y = y;
		q_entry.hit = hit;
		q_entry.idx = idx;
		q_entry.mask = mask;
		q_entry.rv = rv_n;
		q_entry.rx = rx_n;
		q_entry.ry = ry_n;
		q_entry.st = st;
		q_entry.sidx = sidx;
		q_entry.smask = (st == ST_FEW_PTS) ? smask : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 10'd10;
			height_q <= 10'd10;
			trace_count_q <= 3'd1;
			ref_colors_q <= '0;
			trace_colors_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:        width_q <= cfg_data[COORD_W-1:0];
				REG_HEIGHT:       height_q <= cfg_data[COORD_W-1:0];
				REG_TRACE_COUNT:  trace_count_q <= cfg_data[2:0];
				REG_REF_COLORS:   ref_colors_q <= cfg_data;
				REG_TRACE_COLORS: trace_colors_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			first_seen_q <= 1'b0;
			first_bad_q <= 1'b0;
			excess_q <= 1'b0;
			rv_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
			tp_q <= '0;
		end else if (accept) begin
			if (final_pixel) begin
				col_q <= '0;
				row_q <= '0;
				first_seen_q <= 1'b0;
				first_bad_q <= 1'b0;
				excess_q <= 1'b0;
				rv_q <= '0;
				rx_q <= '0;
				ry_q <= '0;
				tp_q <= '0;
			end else begin
				col_q <= col_n;
				row_q <= row_n;
				first_seen_q <= 1'b1;
				first_bad_q <= first_bad_n;
				excess_q <= excess_n;
				rv_q <= rv_n;
				rx_q <= rx_n;
				ry_q <= ry_n;
				tp_q <= tp_n;
			end
		end
	end

endmodule

@@ sv/ckpe_fifo.sv @@
// Short queue of classified pixel entries between front and back end.
// Depends on ckpe_pkg for the entry type.
module ckpe_fifo import ckpe_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  ckpe_entry_t push_entry,
	input  logic        pop,
	output logic        full,
	output logic        not_empty,
	output ckpe_entry_t head
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ckpe_entry_t    mem_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push, do_pop;

	assign full = cnt_q == CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ sv/ckpe_back.sv @@
// Back end: expands queue entries into output records behind an output register.
// A final pixel entry yields its pixel record, four reference points and a status.
// Depends on ckpe_pkg.
module ckpe_back import ckpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  ckpe_entry_t q_head,
	output logic        q_pop,
	output logic        record_valid,
	input  logic        record_ready,
	output logic [1:0]  record_kind,
	output logic [9:0]  coord_x,
	output logic [9:0]  coord_y,
	output logic        ref_hit,
	output logic [1:0]  ref_index,
	output logic [3:0]  trace_mask,
	output logic [2:0]  status,
	output logic        end_of_run
);

	logic        valid_q;
	logic [2:0]  sub_q;
	logic        load;
	logic [1:0]  ri;
	rec_kind_t   kind_d;
	logic [9:0]  x_d, y_d;
	logic        hit_d, eor_d;
	logic [1:0]  idx_d;
	logic [3:0]  mask_d;
	status_t     st_d;

	assign load = (!valid_q || record_ready) && q_not_empty;
	assign q_pop = load && (!q_head.is_last || (sub_q == SUB_STATUS));
	assign ri = 2'(sub_q - 3'd1);
	assign record_valid = valid_q;

	always_comb begin
		kind_d = REC_PIXEL;
		x_d = q_head.x;
		y_d = q_head.y;
		hit_d = q_head.hit;
		idx_d = q_head.idx;
		mask_d = q_head.mask;
		st_d = ST_OK;
		eor_d = !q_head.is_last;
		if (sub_q == SUB_STATUS) begin
			kind_d = REC_STATUS;
			x_d = '0;
			y_d = '0;
			hit_d = 1'b0;
			idx_d = q_head.sidx;
			mask_d = q_head.smask;
			st_d = q_head.st;
			eor_d = 1'b1;
		end else if (sub_q != SUB_PIXEL) begin
			kind_d = REC_REF;
			x_d = q_head.rx[ri];
			y_d = q_head.ry[ri];
			hit_d = q_head.rv[ri];
			idx_d = ri;
			mask_d = '0;
			eor_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sub_q <= (q_head.is_last && (sub_q != SUB_STATUS)) ? sub_q + 3'd1 : '0;
			end else if (record_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			record_kind <= kind_d;
			coord_x <= x_d;
			coord_y <= y_d;
			ref_hit <= hit_d;
			ref_index <= idx_d;
			trace_mask <= mask_d;
			status <= st_d;
			end_of_run <= eor_d;
		end
	end

endmodule

@@ sv/color_key_point_extractor.sv @@
// Top level of the colour key point extractor.
// Instantiates front end, entry queue and back end; depends on ckpe_pkg.
//
// Usage: pixels of a palette image enter in raster order on the pixel channel
// (pixel_color, final_pixel) with pixel_valid/pixel_ready. Each pixel beat gives
// one classification record on the record channel (record_valid/record_ready);
// a beat marked final_pixel gives that record followed by four reference point
// records and one status record, the last with end_of_run set.
// Registers are written on the cfg channel (cfg_index, cfg_data); cfg_ready is
// always high and a write takes effect on the next pixel.
// A record passes through a queue entry and then the output register once its
// pixel beat is taken. Pixel beats are taken one per cycle while the queue is
// not full; a final pixel occupies the output for six records, which the queue
// of QUEUE_DEPTH entries absorbs along with short receiver stalls; when it
// fills, pixel_ready falls until the receiver takes records.
// Reset clears configuration to its defaults, the per-image state and the
// queue; the block takes pixels from the first cycle after reset.
module color_key_point_extractor import ckpe_pkg::*; #(
	parameter int COLOR_BITS = DEF_COLOR_BITS,
	parameter int MIN_TRACE_POINTS = DEF_MIN_TRACE_POINTS,
	parameter int MAX_TRACES = DEF_MAX_TRACES,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  logic [7:0]  pixel_color,
	input  logic        final_pixel,
	output logic        record_valid,
	input  logic        record_ready,
	output logic [1:0]  record_kind,
	output logic [9:0]  coord_x,
	output logic [9:0]  coord_y,
	output logic        ref_hit,
	output logic [1:0]  ref_index,
	output logic [3:0]  trace_mask,
	output logic [2:0]  status,
	output logic        end_of_run
);

	logic        q_full, q_push, q_pop, q_not_empty;
	ckpe_entry_t q_entry, q_head;

	ckpe_front #(
		.COLOR_BITS(COLOR_BITS),
		.MIN_TRACE_POINTS(MIN_TRACE_POINTS),
		.MAX_TRACES(MAX_TRACES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel_color(pixel_color),
		.final_pixel(final_pixel),
		.q_full(q_full),
		.q_push(q_push),
		.q_entry(q_entry)
	);

	ckpe_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_entry(q_entry),
		.pop(q_pop),
		.full(q_full),
		.not_empty(q_not_empty),
		.head(q_head)
	);

	ckpe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(q_not_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.record_valid(record_valid),
		.record_ready(record_ready),
		.record_kind(record_kind),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.ref_hit(ref_hit),
		.ref_index(ref_index),
		.trace_mask(trace_mask),
		.status(status),
		.end_of_run(end_of_run)
	);

endmodule

@@ sv/ckpe_checker.sv @@
// Port-level checker for the colour key point extractor, bound to the top level.
// Depends on ckpe_pkg for the record and status codes.
module ckpe_checker import ckpe_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        record_valid,
	input logic        record_ready,
	input logic [1:0]  record_kind,
	input logic [9:0]  coord_x,
	input logic [9:0]  coord_y,
	input logic [1:0]  ref_index,
	input logic [3:0]  trace_mask,
	input logic [2:0]  status,
	input logic        end_of_run
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && !record_ready |=> record_valid && $stable(record_kind)
		&& $stable(coord_x) && $stable(coord_y) && $stable(status))
		else $error("record beat changed while stalled");

	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && (record_kind == REC_STATUS) |-> end_of_run)
		else $error("status record without end of run");

	a_ref_clean: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && (record_kind == REC_REF) |->
		(trace_mask == 4'd0) && (status == ST_OK) && !end_of_run)
		else $error("reference point record carries stray fields");

	a_status_follows: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && record_ready && (record_kind == REC_REF) && (ref_index == 2'd3)
		|=> record_valid && (record_kind == REC_STATUS))
		else $error("status record did not follow the last reference point");

endmodule

bind color_key_point_extractor ckpe_checker u_ckpe_checker (.*);
